// ===== hdl/lfjt_pkg.sv =====
package lfjt_pkg;

	// Number of CORDIC rotations (8 to 24).
	localparam int CORDIC_STEPS = 16;

	// Angle path: units of 2^-24 rad.
	localparam int ANG_W = 28;
	localparam int RAW_W = 29;
	localparam logic signed [RAW_W-1:0] ANG_PI = 29'sd52707179;
	localparam logic signed [RAW_W-1:0] ANG_TWO_PI = 29'sd105414358;
	localparam logic signed [RAW_W-1:0] ANG_HALF_PI = 29'sd26353589;

	// CORDIC datapath: units of 2^-30, started at the inverse gain.
	localparam int CX_W = 33;
	localparam logic signed [CX_W-1:0] GAIN_Q30 = 33'sd652032874;

	// Sine and cosine in units of 2^-16.
	localparam int TRIG_W = 18;

	// Result queue.
	localparam int OUT_DEPTH = 32;
	localparam int OQ_AW = 5;
	localparam int OQ_CW = 6;

	// Work queue between front and back.
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW = 2;
	localparam int MQ_CW = 3;

	// Register indexes.
	localparam logic [1:0] REG_THIGH = 2'd0;
	localparam logic [1:0] REG_SHANK = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	localparam logic signed [31:0] TORQUE_MAX = 32'sd8388607;
	localparam logic signed [31:0] TORQUE_MIN = -32'sd8388608;

	typedef struct packed {
		logic [1:0] leg;
		logic signed [ANG_W-1:0] za;
		logic signed [ANG_W-1:0] zb;
		logic signed [ANG_W-1:0] zc;
		logic na;
		logic nb;
		logic nc;
		logic signed [23:0] fx;
		logic signed [23:0] fy;
		logic signed [23:0] fz;
	} lfjt_job_t;

	typedef struct packed {
		logic [1:0] leg;
		logic na;
		logic nb;
		logic nc;
		logic signed [23:0] fx;
		logic signed [23:0] fy;
		logic signed [23:0] fz;
	} lfjt_side_t;

	typedef struct packed {
		logic signed [23:0] t0;
		logic signed [23:0] t1;
		logic signed [23:0] t2;
		logic sat;
	} lfjt_res_t;

	typedef struct packed {
		logic [15:0] l1;
		logic [15:0] l2;
		logic [15:0] d;
	} lfjt_geom_t;

	// atan(2^-i) in units of 2^-24 rad.
	function automatic logic signed [ANG_W-1:0] atan_at(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0: r = 28'sd13176795;
			1: r = 28'sd7778716;
			2: r = 28'sd4110060;
			3: r = 28'sd2086331;
			4: r = 28'sd1047214;
			5: r = 28'sd524117;
			6: r = 28'sd262123;
			7: r = 28'sd131069;
			8: r = 28'sd65536;
			9: r = 28'sd32768;
			10: r = 28'sd16384;
			11: r = 28'sd8192;
			12: r = 28'sd4096;
			13: r = 28'sd2048;
			14: r = 28'sd1024;
			15: r = 28'sd512;
			16: r = 28'sd256;
			17: r = 28'sd128;
			18: r = 28'sd64;
			19: r = 28'sd32;
			20: r = 28'sd16;
			21: r = 28'sd8;
			22: r = 28'sd4;
			23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round half up by 16 bits.
	function automatic logic signed [31:0] rnd16(input logic signed [47:0] v);
		logic signed [47:0] t;
		t = (v + 48'sd32768) >>> 16;
		return t[31:0];
	endfunction

endpackage

// ===== hdl/lfjt_front.sv =====
module lfjt_front (
	input logic push,
	output logic full,
	input logic [1:0] leg,
	input logic signed [16:0] hip_roll_angle,
	input logic signed [16:0] hip_pitch_angle,
	input logic signed [16:0] knee_angle,
	input logic signed [23:0] force_x,
	input logic signed [23:0] force_y,
	input logic signed [23:0] force_z,
	input logic mq_full,
	output logic mq_wr,
	output lfjt_pkg::lfjt_job_t mq_wdata
);

	logic signed [17:0] bc_sum;
	logic signed [lfjt_pkg::RAW_W-1:0] raw_a;
	logic signed [lfjt_pkg::RAW_W-1:0] raw_b;
	logic signed [lfjt_pkg::RAW_W-1:0] raw_c;
	logic signed [lfjt_pkg::RAW_W-1:0] red_a;
	logic signed [lfjt_pkg::RAW_W-1:0] red_b;
	logic signed [lfjt_pkg::RAW_W-1:0] red_c;
	logic neg_a;
	logic neg_b;
	logic neg_c;

	// Bring an angle into +-pi/2; the flag says sine and cosine change sign.
	function automatic void reduce(input logic signed [lfjt_pkg::RAW_W-1:0] z_in,
			output logic signed [lfjt_pkg::RAW_W-1:0] z_out, output logic neg);
		logic signed [lfjt_pkg::RAW_W-1:0] z;
		z = z_in;
		neg = 1'b0;
		if (z > lfjt_pkg::ANG_PI) begin
			z = z - lfjt_pkg::ANG_TWO_PI;
		end
		if (z < -lfjt_pkg::ANG_PI) begin
			z = z + lfjt_pkg::ANG_TWO_PI;
		end
		if (z > lfjt_pkg::ANG_HALF_PI) begin
			z = z - lfjt_pkg::ANG_PI;
			neg = 1'b1;
		end else if (z < -lfjt_pkg::ANG_HALF_PI) begin
			z = z + lfjt_pkg::ANG_PI;
			neg = 1'b1;
		end
		z_out = z;
	endfunction

	// Scale the three angles to 2^-24 rad; the knee works on pitch plus knee.
	assign bc_sum = 18'(hip_pitch_angle) + 18'(knee_angle);
	assign raw_a = {{2{hip_roll_angle[16]}}, hip_roll_angle, 10'b0};
	assign raw_b = {{2{hip_pitch_angle[16]}}, hip_pitch_angle, 10'b0};
	assign raw_c = {bc_sum[17], bc_sum, 10'b0};

	always_comb begin
		reduce(raw_a, red_a, neg_a);
		reduce(raw_b, red_b, neg_b);
		reduce(raw_c, red_c, neg_c);
	end

	// Classified item into the work queue.
	always_comb begin
		mq_wdata.leg = leg;
		mq_wdata.za = red_a[lfjt_pkg::ANG_W-1:0];
		mq_wdata.zb = red_b[lfjt_pkg::ANG_W-1:0];
		mq_wdata.zc = red_c[lfjt_pkg::ANG_W-1:0];
		mq_wdata.na = neg_a;
		mq_wdata.nb = neg_b;
		mq_wdata.nc = neg_c;
		mq_wdata.fx = force_x;
		mq_wdata.fy = force_y;
		mq_wdata.fz = force_z;
	end

	assign full = mq_full;
	assign mq_wr = push && !mq_full;

endmodule

// ===== hdl/lfjt_mid_queue.sv =====
module lfjt_mid_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input lfjt_pkg::lfjt_job_t wdata,
	output logic full,
	input logic rd,
	output lfjt_pkg::lfjt_job_t rdata,
	output logic empty
);

	lfjt_pkg::lfjt_job_t mem_q [0:lfjt_pkg::MQ_DEPTH-1];
	logic [lfjt_pkg::MQ_AW-1:0] wptr_q;
	logic [lfjt_pkg::MQ_AW-1:0] rptr_q;
	logic [lfjt_pkg::MQ_CW-1:0] count_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + lfjt_pkg::MQ_CW'(wr) - lfjt_pkg::MQ_CW'(rd);
		end
	end

	assign full = (count_q == lfjt_pkg::MQ_CW'(lfjt_pkg::MQ_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

endmodule

// ===== hdl/lfjt_back.sv =====
module lfjt_back (
	input logic clk,
	input logic arst_n,
	input lfjt_pkg::lfjt_geom_t geom,
	input logic mq_empty,
	input lfjt_pkg::lfjt_job_t mq_rdata,
	output logic mq_rd,
	input logic out_taken,
	output logic oq_wr,
	output lfjt_pkg::lfjt_res_t oq_wdata
);

	localparam int STEPS = lfjt_pkg::CORDIC_STEPS;

	logic [lfjt_pkg::OQ_CW-1:0] credit_q;

	logic vld_s [0:STEPS];
	logic signed [lfjt_pkg::CX_W-1:0] cx_s [0:STEPS][0:2];
	logic signed [lfjt_pkg::CX_W-1:0] cy_s [0:STEPS][0:2];
	logic signed [lfjt_pkg::ANG_W-1:0] cz_s [0:STEPS][0:2];
	lfjt_pkg::lfjt_side_t side_s [0:STEPS];

	logic signed [lfjt_pkg::CX_W-1:0] rx [0:2];
	logic signed [lfjt_pkg::CX_W-1:0] ry [0:2];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [lfjt_pkg::TRIG_W-1:0] ca_s1, sa_s1, cb_s1, sb_s1, cbc_s1, sbc_s1;
	lfjt_pkg::lfjt_side_t side_s1;

	logic signed [34:0] l1sb_s2, l2sbc_s2, l1cb_s2, l2cbc_s2;
	logic signed [41:0] fysa_s2, fzca_s2;
	logic signed [lfjt_pkg::TRIG_W-1:0] ca_s2, sa_s2;
	logic signed [16:0] d_s2;
	logic signed [23:0] fx_s2, fy_s2, fz_s2;

	logic signed [19:0] x_s3, z_s3, x2_s3, z2_s3;
	logic signed [26:0] g_s3;
	logic signed [lfjt_pkg::TRIG_W-1:0] ca_s3, sa_s3;
	logic signed [16:0] d_s3;
	logic signed [23:0] fx_s3, fy_s3, fz_s3;

	logic signed [34:0] dca_s4, dsa_s4;
	logic signed [37:0] zsa_s4, zca_s4;
	logic signed [43:0] fxz_s4, fxz2_s4;
	logic signed [46:0] xg_s4, x2g_s4;
	logic signed [23:0] fy_s4, fz_s4;

	logic signed [21:0] y0_s5, z0_s5;
	logic signed [47:0] t1_s5, t2_s5;
	logic signed [23:0] fy_s5, fz_s5;

	logic signed [45:0] fyz0_s6, fzy0_s6;
	logic signed [47:0] t1_s6, t2_s6;

	lfjt_pkg::lfjt_res_t res_s7;

	logic signed [16:0] l1_sg, l2_sg, d_sg;
	logic signed [31:0] r0, r1, r2;
	logic signed [23:0] k0, k1, k2;
	logic any_sat;

	// Issue from the work queue only while the result queue has a free slot
	// for every item in flight, so the pipeline never has to stop.
	assign mq_rd = !mq_empty && (credit_q < lfjt_pkg::OQ_CW'(lfjt_pkg::OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + lfjt_pkg::OQ_CW'(mq_rd) - lfjt_pkg::OQ_CW'(out_taken);
		end
	end

	// CORDIC entry stage.
	always_ff @(posedge clk) begin
		if (mq_rd) begin
			for (int u = 0; u < 3; u++) begin
				cx_s[0][u] <= lfjt_pkg::GAIN_Q30;
				cy_s[0][u] <= '0;
			end
			cz_s[0][0] <= mq_rdata.za;
			cz_s[0][1] <= mq_rdata.zb;
			cz_s[0][2] <= mq_rdata.zc;
			side_s[0].leg <= mq_rdata.leg;
			side_s[0].na <= mq_rdata.na;
			side_s[0].nb <= mq_rdata.nb;
			side_s[0].nc <= mq_rdata.nc;
			side_s[0].fx <= mq_rdata.fx;
			side_s[0].fy <= mq_rdata.fy;
			side_s[0].fz <= mq_rdata.fz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= mq_rd;
		end
	end

	// One rotation per stage, three angles side by side.
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			for (int u = 0; u < 3; u++) begin
				if (!cz_s[i][u][lfjt_pkg::ANG_W-1]) begin
					cx_s[i+1][u] <= cx_s[i][u] - (cy_s[i][u] >>> i);
					cy_s[i+1][u] <= cy_s[i][u] + (cx_s[i][u] >>> i);
					cz_s[i+1][u] <= cz_s[i][u] - lfjt_pkg::atan_at(i);
				end else begin
					cx_s[i+1][u] <= cx_s[i][u] + (cy_s[i][u] >>> i);
					cy_s[i+1][u] <= cy_s[i][u] - (cx_s[i][u] >>> i);
					cz_s[i+1][u] <= cz_s[i][u] + lfjt_pkg::atan_at(i);
				end
			end
			side_s[i+1] <= side_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	// Round cosine and sine to 2^-16 and apply the half-turn sign.
	always_comb begin
		for (int u = 0; u < 3; u++) begin
			rx[u] = (cx_s[STEPS][u] + 33'sd8192) >>> 14;
			ry[u] = (cy_s[STEPS][u] + 33'sd8192) >>> 14;
		end
	end

	always_ff @(posedge clk) begin
		ca_s1 <= side_s[STEPS].na ? -rx[0][lfjt_pkg::TRIG_W-1:0] : rx[0][lfjt_pkg::TRIG_W-1:0];
		sa_s1 <= side_s[STEPS].na ? -ry[0][lfjt_pkg::TRIG_W-1:0] : ry[0][lfjt_pkg::TRIG_W-1:0];
		cb_s1 <= side_s[STEPS].nb ? -rx[1][lfjt_pkg::TRIG_W-1:0] : rx[1][lfjt_pkg::TRIG_W-1:0];
		sb_s1 <= side_s[STEPS].nb ? -ry[1][lfjt_pkg::TRIG_W-1:0] : ry[1][lfjt_pkg::TRIG_W-1:0];
		cbc_s1 <= side_s[STEPS].nc ? -rx[2][lfjt_pkg::TRIG_W-1:0] : rx[2][lfjt_pkg::TRIG_W-1:0];
		sbc_s1 <= side_s[STEPS].nc ? -ry[2][lfjt_pkg::TRIG_W-1:0] : ry[2][lfjt_pkg::TRIG_W-1:0];
		side_s1 <= side_s[STEPS];
	end

	// Link lengths and the signed hip offset.
	assign l1_sg = {1'b0, geom.l1};
	assign l2_sg = {1'b0, geom.l2};
	assign d_sg = side_s1.leg[0] ? -{1'b0, geom.d} : {1'b0, geom.d};

	// Link products and the rolled force products.
	always_ff @(posedge clk) begin
		l1sb_s2 <= l1_sg * sb_s1;
		l2sbc_s2 <= l2_sg * sbc_s1;
		l1cb_s2 <= l1_sg * cb_s1;
		l2cbc_s2 <= l2_sg * cbc_s1;
		fysa_s2 <= side_s1.fy * sa_s1;
		fzca_s2 <= side_s1.fz * ca_s1;
		ca_s2 <= ca_s1;
		sa_s2 <= sa_s1;
		d_s2 <= d_sg;
		fx_s2 <= side_s1.fx;
		fy_s2 <= side_s1.fy;
		fz_s2 <= side_s1.fz;
	end

	// Foot position in the leg plane and the rolled force G.
	always_ff @(posedge clk) begin
		x2_s3 <= 20'(lfjt_pkg::rnd16(48'(l2sbc_s2)));
		z2_s3 <= 20'(lfjt_pkg::rnd16(-48'(l2cbc_s2)));
		x_s3 <= 20'(lfjt_pkg::rnd16(48'(l1sb_s2) + 48'(l2sbc_s2)));
		z_s3 <= 20'(lfjt_pkg::rnd16(-(48'(l1cb_s2) + 48'(l2cbc_s2))));
		g_s3 <= 27'(lfjt_pkg::rnd16(48'(fysa_s2) + 48'(fzca_s2)));
		ca_s3 <= ca_s2;
		sa_s3 <= sa_s2;
		d_s3 <= d_s2;
		fx_s3 <= fx_s2;
		fy_s3 <= fy_s2;
		fz_s3 <= fz_s2;
	end

	// Roll products and the pitch torque products.
	always_ff @(posedge clk) begin
		dca_s4 <= d_s3 * ca_s3;
		dsa_s4 <= d_s3 * sa_s3;
		zsa_s4 <= z_s3 * sa_s3;
		zca_s4 <= z_s3 * ca_s3;
		fxz_s4 <= fx_s3 * z_s3;
		fxz2_s4 <= fx_s3 * z2_s3;
		xg_s4 <= x_s3 * g_s3;
		x2g_s4 <= x2_s3 * g_s3;
		fy_s4 <= fy_s3;
		fz_s4 <= fz_s3;
	end

	// Foot position in the body frame and the pitch torque sums.
	always_ff @(posedge clk) begin
		y0_s5 <= 22'(lfjt_pkg::rnd16(48'(dca_s4) + 48'(zsa_s4)));
		z0_s5 <= 22'(lfjt_pkg::rnd16(48'(zca_s4) - 48'(dsa_s4)));
		t1_s5 <= 48'(xg_s4) - 48'(fxz_s4);
		t2_s5 <= 48'(x2g_s4) - 48'(fxz2_s4);
		fy_s5 <= fy_s4;
		fz_s5 <= fz_s4;
	end

	// Roll torque products.
	always_ff @(posedge clk) begin
		fyz0_s6 <= fy_s5 * z0_s5;
		fzy0_s6 <= fz_s5 * y0_s5;
		t1_s6 <= t1_s5;
		t2_s6 <= t2_s5;
	end

	// Final rounding and clipping.
	function automatic logic signed [23:0] clip(input logic signed [31:0] v);
		logic signed [31:0] c;
		if (v > lfjt_pkg::TORQUE_MAX) begin
			c = lfjt_pkg::TORQUE_MAX;
		end else if (v < lfjt_pkg::TORQUE_MIN) begin
			c = lfjt_pkg::TORQUE_MIN;
		end else begin
			c = v;
		end
		return c[23:0];
	endfunction

	always_comb begin
		r0 = lfjt_pkg::rnd16(48'(fyz0_s6) - 48'(fzy0_s6));
		r1 = lfjt_pkg::rnd16(t1_s6);
		r2 = lfjt_pkg::rnd16(t2_s6);
		k0 = clip(r0);
		k1 = clip(r1);
		k2 = clip(r2);
		any_sat = (32'(k0) != r0) || (32'(k1) != r1) || (32'(k2) != r2);
	end

	always_ff @(posedge clk) begin
		res_s7.t0 <= k0;
		res_s7.t1 <= k1;
		res_s7.t2 <= k2;
		res_s7.sat <= any_sat;
	end

	// Valid bits behind the rotations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= vld_s[STEPS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign oq_wr = vld_s7;
	assign oq_wdata = res_s7;

endmodule

// ===== hdl/lfjt_out_queue.sv =====
module lfjt_out_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input lfjt_pkg::lfjt_res_t wdata,
	output logic full,
	input logic rd,
	output lfjt_pkg::lfjt_res_t rdata,
	output logic empty
);

	lfjt_pkg::lfjt_res_t mem_q [0:lfjt_pkg::OUT_DEPTH-1];
	logic [lfjt_pkg::OQ_AW-1:0] wptr_q;
	logic [lfjt_pkg::OQ_AW-1:0] rptr_q;
	logic [lfjt_pkg::OQ_CW-1:0] count_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + lfjt_pkg::OQ_CW'(wr) - lfjt_pkg::OQ_CW'(rd);
		end
	end

	assign full = (count_q == lfjt_pkg::OQ_CW'(lfjt_pkg::OUT_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

endmodule

// ===== hdl/leg_contact_force_to_joint_torque_core.sv =====
// Leg contact force to joint torque, tau = J^T F, for a roll-pitch-pitch leg.
// Input channel: present an item (leg, three joint angles, foot force) and
// raise push; it is taken at a rising edge with push high and full low.
// Result channel: while empty is low the oldest result (three torques and
// the saturation flag) sits on the outputs; raising pop takes it.
// Results leave in the order the items arrived, one per item.
// Throughput: one item per cycle, sustained, as long as results are popped.
// Behind the unrolled CORDIC pipeline sit seven multiply and round stages.
// A four-entry work queue sits between the angle range reduction and the
// pipeline, and a 32-entry result queue at the end. Items enter the pipeline
// only while every one in flight has a result slot reserved, so a stalled
// receiver fills the result queue, then the work queue, then raises full.
// Reset clears both queues and the pipeline and loads the link registers with
// defaults. Link registers sit at APB byte addresses 0, 4 and 8; the user
// writes them only while no item is in flight, which the block does not check.
module leg_contact_force_to_joint_torque_core (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] leg,
	input logic signed [16:0] hip_roll_angle,
	input logic signed [16:0] hip_pitch_angle,
	input logic signed [16:0] knee_angle,
	input logic signed [23:0] force_x,
	input logic signed [23:0] force_y,
	input logic signed [23:0] force_z,
	output logic empty,
	input logic pop,
	output logic signed [23:0] torque_hip_roll,
	output logic signed [23:0] torque_hip_pitch,
	output logic signed [23:0] torque_knee,
	output logic saturated,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [15:0] thigh_q;
	logic [15:0] shank_q;
	logic [15:0] offset_q;
	logic cfg_wr;

	lfjt_pkg::lfjt_geom_t geom;
	lfjt_pkg::lfjt_job_t mq_wdata;
	lfjt_pkg::lfjt_job_t mq_rdata;
	logic mq_wr, mq_full, mq_rd, mq_empty;
	lfjt_pkg::lfjt_res_t oq_wdata;
	lfjt_pkg::lfjt_res_t oq_rdata;
	logic oq_wr, oq_full, out_taken;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thigh_q <= 16'd13107;
			shank_q <= 16'd13770;
			offset_q <= 16'd6380;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lfjt_pkg::REG_THIGH: thigh_q <= pwdata[15:0];
				lfjt_pkg::REG_SHANK: shank_q <= pwdata[15:0];
				lfjt_pkg::REG_OFFSET: offset_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lfjt_pkg::REG_THIGH: prdata = {16'd0, thigh_q};
			lfjt_pkg::REG_SHANK: prdata = {16'd0, shank_q};
			lfjt_pkg::REG_OFFSET: prdata = {16'd0, offset_q};
			default: prdata = '0;
		endcase
	end

	assign geom.l1 = thigh_q;
	assign geom.l2 = shank_q;
	assign geom.d = offset_q;

	// Front: accept and range-reduce.
	lfjt_front u_front (
		.push(push),
		.full(full),
		.leg(leg),
		.hip_roll_angle(hip_roll_angle),
		.hip_pitch_angle(hip_pitch_angle),
		.knee_angle(knee_angle),
		.force_x(force_x),
		.force_y(force_y),
		.force_z(force_z),
		.mq_full(mq_full),
		.mq_wr(mq_wr),
		.mq_wdata(mq_wdata)
	);

	lfjt_mid_queue u_mid_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(mq_wr),
		.wdata(mq_wdata),
		.full(mq_full),
		.rd(mq_rd),
		.rdata(mq_rdata),
		.empty(mq_empty)
	);

	// Back: CORDIC and torque pipeline.
	lfjt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.geom(geom),
		.mq_empty(mq_empty),
		.mq_rdata(mq_rdata),
		.mq_rd(mq_rd),
		.out_taken(out_taken),
		.oq_wr(oq_wr),
		.oq_wdata(oq_wdata)
	);

	assign out_taken = pop && !empty;

	lfjt_out_queue u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(oq_wr),
		.wdata(oq_wdata),
		.full(oq_full),
		.rd(out_taken),
		.rdata(oq_rdata),
		.empty(empty)
	);

	assign torque_hip_roll = oq_rdata.t0;
	assign torque_hip_pitch = oq_rdata.t1;
	assign torque_knee = oq_rdata.t2;
	assign saturated = oq_rdata.sat;

	// The slot reservation must keep the result queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_wr |-> (!oq_full || out_taken))
		else $error("result queue written while full");

	// An accepted item must be waiting in the work queue in the next cycle.
	a_item_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !mq_empty)
		else $error("accepted item missing from work queue");

	// The pipeline only draws from a non-empty work queue.
	a_issue_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mq_rd |-> !mq_empty)
		else $error("issue from empty work queue");

endmodule
